@@ hdl/wtnc_pkg.sv @@
// wtnc_pkg: types, event and error codes, character constants and the
// queue entry shared by the tokenizer front, queue, back and top level.
// No dependencies.
`timescale 1ns / 1ps

package wtnc_pkg;

  typedef enum logic [2:0] {
    KIND_CHAR = 3'd0,
    KIND_WEND = 3'd1,
    KIND_IEND = 3'd2,
    KIND_END  = 3'd3,
    KIND_ERR  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_END_ESCAPE  = 3'd1,
    ERR_END_COMMENT = 3'd2,
    ERR_STRAY_CLOSE = 3'd3,
    ERR_TOO_DEEP    = 3'd4
  } err_t;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic [31:0] POS_MAX = 32'hFFFF_FFFF;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // One classified input item: an optional word end, then the main event
  typedef struct packed {
    logic        has_wend;
    kind_t       main_kind;
    logic [7:0]  ch;
    logic        esc;
    logic [31:0] line;
    logic [31:0] col;
    err_t        code;
  } entry_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

endpackage

@@ hdl/wtnc_front.sv @@
// wtnc_front: accepts characters, tracks comment depth, escape, word and
// position state, and pushes one classified entry per result-bearing item.
// Depends on wtnc_pkg.
`timescale 1ns / 1ps

module wtnc_front import wtnc_pkg::*; #(
  parameter int MAX_COMMENT_DEPTH = 15
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       is_end,
  input  logic       q_full,
  output logic       push,
  output entry_t     push_entry
);

  localparam int DW = $clog2(MAX_COMMENT_DEPTH + 1);
  localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_COMMENT_DEPTH);

  logic [DW-1:0] comment_depth, comment_depth_next;
  logic          escape_pending, escape_pending_next;
  logic          inside_word, inside_word_next;
  logic [31:0]   line_count, line_count_next;
  logic [31:0]   column_count, column_count_next;
  logic          prev_was_newline, prev_was_newline_next;
  logic          error_latched, error_latched_next;
  logic          produce;
  logic          accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && produce;

  always_comb begin
    comment_depth_next    = comment_depth;
    escape_pending_next   = escape_pending;
    inside_word_next      = inside_word;
    line_count_next       = line_count;
    column_count_next     = column_count;
    prev_was_newline_next = prev_was_newline;
    error_latched_next    = error_latched;
    produce               = 1'b0;
    push_entry.has_wend   = 1'b0;
    push_entry.main_kind  = KIND_CHAR;
    push_entry.ch         = 8'd0;
    push_entry.esc        = 1'b0;
    push_entry.line       = line_count;
    push_entry.col        = column_count;
    push_entry.code       = ERR_NONE;

    if (!error_latched) begin
      if (is_end) begin
        if (escape_pending) begin
          produce              = 1'b1;
          push_entry.main_kind = KIND_ERR;
          push_entry.code      = ERR_END_ESCAPE;
          error_latched_next   = 1'b1;
        end else if (comment_depth != '0) begin
          produce              = 1'b1;
          push_entry.main_kind = KIND_ERR;
          push_entry.code      = ERR_END_COMMENT;
          error_latched_next   = 1'b1;
        end else begin
          produce              = 1'b1;
          push_entry.has_wend  = inside_word;
          push_entry.main_kind = KIND_END;
          inside_word_next     = 1'b0;
        end
      end else begin
        // Advance position, saturating
        if (prev_was_newline) begin
          if (line_count != POS_MAX) begin
            line_count_next = line_count + 32'd1;
          end
          column_count_next = 32'd1;
        end else if (column_count != POS_MAX) begin
          column_count_next = column_count + 32'd1;
        end
        prev_was_newline_next = (in_char == CH_LF);
        push_entry.line       = line_count_next;
        push_entry.col        = column_count_next;

        if (escape_pending) begin
          escape_pending_next = 1'b0;
          if (comment_depth == '0) begin
            produce              = 1'b1;
            push_entry.main_kind = KIND_CHAR;
            push_entry.ch        = in_char;
            push_entry.esc       = 1'b1;
            inside_word_next     = 1'b1;
          end
        end else if (in_char == CH_BSLASH) begin
          escape_pending_next = 1'b1;
        end else if (in_char == CH_LBRACE) begin
          if (comment_depth >= DEPTH_MAX) begin
            produce              = 1'b1;
            push_entry.main_kind = KIND_ERR;
            push_entry.code      = ERR_TOO_DEEP;
            error_latched_next   = 1'b1;
          end else begin
            comment_depth_next = comment_depth + DW'(1);
          end
        end else if (in_char == CH_RBRACE) begin
          if (comment_depth == '0) begin
            produce              = 1'b1;
            push_entry.main_kind = KIND_ERR;
            push_entry.code      = ERR_STRAY_CLOSE;
            error_latched_next   = 1'b1;
          end else begin
            comment_depth_next = comment_depth - DW'(1);
          end
        end else if (comment_depth != '0) begin
          // drop comment text
        end else if (in_char == CH_SEMI) begin
          produce              = 1'b1;
          push_entry.has_wend  = inside_word;
          push_entry.main_kind = KIND_IEND;
          inside_word_next     = 1'b0;
        end else if (is_blank(in_char)) begin
          produce              = inside_word;
          push_entry.main_kind = KIND_WEND;
          inside_word_next     = 1'b0;
        end else begin
          produce              = 1'b1;
          push_entry.main_kind = KIND_CHAR;
          push_entry.ch        = in_char;
          inside_word_next     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      comment_depth    <= '0;
      escape_pending   <= 1'b0;
      inside_word      <= 1'b0;
      line_count       <= 32'd1;
      column_count     <= 32'd0;
      prev_was_newline <= 1'b0;
      error_latched    <= 1'b0;
    end else if (accept) begin
      comment_depth    <= comment_depth_next;
      escape_pending   <= escape_pending_next;
      inside_word      <= inside_word_next;
      line_count       <= line_count_next;
      column_count     <= column_count_next;
      prev_was_newline <= prev_was_newline_next;
      error_latched    <= error_latched_next;
    end
  end

endmodule

@@ hdl/wtnc_fifo.sv @@
// wtnc_fifo: short queue of classified entries between front and back.
// Depends on wtnc_pkg.
`timescale 1ns / 1ps

module wtnc_fifo import wtnc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   head_valid,
  output entry_t head
);

  entry_t         mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full       = (count == (QAW + 1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QAW + 1)'(1);
        2'b01:   count <= count - (QAW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/wtnc_back.sv @@
// wtnc_back: expands each queued entry into one or two result items and
// holds them in the output register until taken. Depends on wtnc_pkg.
`timescale 1ns / 1ps

module wtnc_back import wtnc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  entry_t      head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output kind_t       out_kind,
  output logic [7:0]  out_char,
  output logic        out_esc,
  output logic [31:0] out_line,
  output logic [31:0] out_col,
  output err_t        out_code,
  output logic        out_last
);

  logic load;
  logic wend_step;
  logic phase;

  assign load      = head_valid && (!out_valid || out_ready);
  assign wend_step = head.has_wend && !phase;
  assign pop       = load && !wend_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= wend_step;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_line <= head.line;
      out_col  <= head.col;
      if (wend_step) begin
        out_kind <= KIND_WEND;
        out_char <= 8'd0;
        out_esc  <= 1'b0;
        out_code <= ERR_NONE;
        out_last <= 1'b0;
      end else begin
        out_kind <= head.main_kind;
        out_char <= head.ch;
        out_esc  <= head.esc;
        out_code <= head.code;
        out_last <= 1'b1;
      end
    end
  end

endmodule

@@ hdl/word_tokenizer_nested_comments.sv @@
// word_tokenizer_nested_comments: top level of the word tokenizer with
// nestable brace comments. Instantiates wtnc_front, wtnc_fifo and wtnc_back;
// depends on wtnc_pkg.
//
// Usage:
//   The s_axis channel carries one item per character: tdata holds the byte,
//   tuser[0] marks end of input instead of a character. The m_axis channel
//   carries events: word character, word end, instruction end, input end and
//   error, each with the line and column of the causing character.
//   An item produces zero, one or two events; tlast marks the final event
//   of an item.
// Throughput: one input item per cycle while the queue has room; the back
//   end issues one event per cycle while m_axis_tready is high, so items
//   with two events (word end then instruction/input end) are absorbed by
//   the four-entry queue.
// Path: the front writes the queue at the accepting edge, then the back
//   loads the output register, which drives m_axis_tvalid; a second event
//   of the same item is loaded from the same queue entry once the first
//   is taken.
// Reset: rst clears depth, escape, word and error state, sets line to 1 and
//   column to 0, and empties the queue and output register.
// Stalls: when m_axis_tready is low the output register holds; the queue
//   fills and s_axis_tready drops only when all four entries are taken.
// After an error event the block keeps accepting items but emits nothing
//   until reset.
`timescale 1ns / 1ps

module word_tokenizer_nested_comments import wtnc_pkg::*; #(
  parameter int MAX_COMMENT_DEPTH = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
  input  logic [0:0]  s_axis_tuser,   // [0] is_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_char, [8] was_escaped, [40:9] line_no, [72:41] column_no,
  // [75:73] error_code, [79:76] zero
  output logic [79:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast
);

  logic   q_full;
  logic   q_push;
  entry_t q_push_entry;
  logic   q_pop;
  logic   q_head_valid;
  entry_t q_head;

  kind_t       out_kind;
  logic [7:0]  out_char;
  logic        out_esc;
  logic [31:0] out_line;
  logic [31:0] out_col;
  err_t        out_code;

  // Classify characters and update tokenizer state
  wtnc_front #(
    .MAX_COMMENT_DEPTH(MAX_COMMENT_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_char    (s_axis_tdata),
    .is_end     (s_axis_tuser[0]),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (q_push_entry)
  );

  // Decouple front from output backpressure
  wtnc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // Expand entries into events
  wtnc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_kind   (out_kind),
    .out_char   (out_char),
    .out_esc    (out_esc),
    .out_line   (out_line),
    .out_col    (out_col),
    .out_code   (out_code),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tuser = out_kind;
  assign m_axis_tdata = {4'd0, out_code, out_col, out_line, out_esc, out_char};

  // Never write into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("push into full queue");

  // Only a word end may precede another event of the same item
  a_nonlast_is_wend: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (out_kind == KIND_WEND))
    else $error("non-final event is not a word end");

  // Error code is set exactly on error events
  a_code_matches_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((out_kind == KIND_ERR) == (out_code != ERR_NONE)))
    else $error("error code and kind disagree");

  // An error event is always the last event of its item
  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (out_kind == KIND_ERR)) |-> m_axis_tlast)
    else $error("error event not marked last");

endmodule

@@ tb/tb_word_tokenizer_nested_comments.sv @@
// tb_word_tokenizer_nested_comments: self-checking bench for the nested-comment word tokenizer.
// A scoreboard class predicts every event and checks them in order; plain tasks drive the
// streams with random gaps and stalls. Depends on wtnc_pkg and word_tokenizer_nested_comments.
`timescale 1ns / 1ps

module tb_word_tokenizer_nested_comments;
  import wtnc_pkg::*;

  localparam int DEPTH_LIMIT    = 15;
  localparam int RANDOM_ITEMS   = 1050;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;

  // One predicted event on the output stream
  typedef struct {
    kind_t       kind;
    logic [7:0]  ch;
    logic        esc;
    logic [31:0] line;
    logic [31:0] col;
    err_t        code;
    logic        last;
  } tok_event_t;

  // Predicts the tokenizer from accepted items and checks events in order
  class token_scoreboard;
    int          max_depth;
    int          depth;
    logic        esc_pend;
    logic        in_word;
    logic        after_lf;
    logic        halted;
    logic [31:0] line;
    logic [31:0] col;
    tok_event_t  pending[$];
    int          mismatches;

    function new(int max_depth_i);
      max_depth  = max_depth_i;
      depth      = 0;
      esc_pend   = 1'b0;
      in_word    = 1'b0;
      after_lf   = 1'b0;
      halted     = 1'b0;
      line       = 32'd1;
      col        = 32'd0;
      mismatches = 0;
    endfunction

    task report(string msg);
      if (mismatches < 40) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    function void add(kind_t k, logic [7:0] c, logic e, err_t code);
      tok_event_t ev;
      ev.kind = k;
      ev.ch   = c;
      ev.esc  = e;
      ev.line = line;
      ev.col  = col;
      ev.code = code;
      ev.last = 1'b0;
      pending.push_back(ev);
    endfunction

    function void raise(err_t code);
      halted = 1'b1;
      add(KIND_ERR, 8'h00, 1'b0, code);
    endfunction

    function logic is_space(logic [7:0] c);
      case (c)
        CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function void note_item(logic [7:0] c, logic is_end);
      int n0;
      n0 = pending.size();
      if (halted) return;
      if (is_end) begin
        // the end mark leaves the position alone
        if (esc_pend) raise(ERR_END_ESCAPE);
        else if (depth != 0) raise(ERR_END_COMMENT);
        else begin
          if (in_word) add(KIND_WEND, 8'h00, 1'b0, ERR_NONE);
          add(KIND_END, 8'h00, 1'b0, ERR_NONE);
          in_word = 1'b0;
        end
      end else begin
        if (after_lf) begin
          if (line != POS_MAX) line++;
          col = 32'd1;
        end else if (col != POS_MAX) begin
          col++;
        end
        after_lf = (c == CH_LF);
        if (esc_pend) begin
          esc_pend = 1'b0;
          if (depth == 0) begin
            add(KIND_CHAR, c, 1'b1, ERR_NONE);
            in_word = 1'b1;
          end
        end else if (c == CH_BSLASH) begin
          esc_pend = 1'b1;
        end else if (c == CH_LBRACE) begin
          if (depth >= max_depth) raise(ERR_TOO_DEEP);
          else depth++;
        end else if (c == CH_RBRACE) begin
          if (depth == 0) raise(ERR_STRAY_CLOSE);
          else depth--;
        end else if (depth == 0) begin
          if (c == CH_SEMI) begin
            if (in_word) add(KIND_WEND, 8'h00, 1'b0, ERR_NONE);
            add(KIND_IEND, 8'h00, 1'b0, ERR_NONE);
            in_word = 1'b0;
          end else if (is_space(c)) begin
            if (in_word) add(KIND_WEND, 8'h00, 1'b0, ERR_NONE);
            in_word = 1'b0;
          end else begin
            add(KIND_CHAR, c, 1'b0, ERR_NONE);
            in_word = 1'b1;
          end
        end
      end
      if (pending.size() > n0) pending[pending.size() - 1].last = 1'b1;
    endfunction

    task check_event(logic [2:0] kind_bits, logic [79:0] data, logic last_bit);
      tok_event_t ev;
      if (pending.size() == 0) begin
        report($sformatf("unexpected event kind %0d", kind_bits));
        return;
      end
      ev = pending.pop_front();
      if (kind_bits !== ev.kind)
        report($sformatf("kind %0d, want %0d", kind_bits, ev.kind));
      if (data[7:0] !== ev.ch)
        report($sformatf("out_char %02h, want %02h", data[7:0], ev.ch));
      if (data[8] !== ev.esc)
        report($sformatf("was_escaped %0b, want %0b", data[8], ev.esc));
      if (data[40:9] !== ev.line)
        report($sformatf("line_no %0d, want %0d", data[40:9], ev.line));
      if (data[72:41] !== ev.col)
        report($sformatf("column_no %0d, want %0d", data[72:41], ev.col));
      if (data[75:73] !== ev.code)
        report($sformatf("error_code %0d, want %0d", data[75:73], ev.code));
      if (last_bit !== ev.last)
        report($sformatf("tlast %0b, want %0b", last_bit, ev.last));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] in_char
  logic [0:0]  s_axis_tuser;   // [0] is_end
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [7:0] out_char, [8] was_escaped, [40:9] line_no, [72:41] column_no,
  // [75:73] error_code, [79:76] zero
  logic [79:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;   // [2:0] kind
  logic        m_axis_tlast;

  token_scoreboard sb;

  // Mirror of the escape and depth state as the stimulus sees it, used to keep
  // random text legal until the deliberate error at the very end
  int   gen_depth;
  logic gen_esc;
  logic src_calm;
  int   sent_items;

  int   idle_cycles;
  int   sink_stall;
  int   sink_tick;
  logic sink_calm;

  word_tokenizer_nested_comments #(
    .MAX_COMMENT_DEPTH(DEPTH_LIMIT)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sample both handshakes at the rising edge: note the item first, then check
  // the event (an item cannot cause an event on its own acceptance edge anyway)
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_item(s_axis_tdata, s_axis_tuser[0]);
      if (m_axis_tvalid && m_axis_tready) sb.check_event(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end
  end

  // Watchdog: give up when neither stream moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
          $display("word_tokenizer_nested_comments verification failed");
          $finish;
        end
      end
    end
  end

  // Receiver back-pressure: alternate calm stretches with bursts of stalls,
  // mostly short ones and now and then a long one
  always @(negedge clk) begin
    sink_tick++;
    if (sink_tick % 400 == 0) sink_calm = !sink_calm;
    if (sink_stall > 0) begin
      sink_stall--;
      m_axis_tready <= 1'b0;
    end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
      sink_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Present one item after a random gap and hold it until accepted; starts and
  // ends at a falling edge
  task automatic send_item(input logic [7:0] c, input logic is_end);
    int gap;
    int roll;
    gap = 0;
    if (!src_calm) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) gap = 0;
      else if (roll < 94) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = c;
    s_axis_tuser  = is_end;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    // track escape and depth the way the block will see them
    if (!is_end) begin
      if (gen_esc) gen_esc = 1'b0;
      else if (c == CH_BSLASH) gen_esc = 1'b1;
      else if (c == CH_LBRACE) gen_depth++;
      else if (c == CH_RBRACE && gen_depth > 0) gen_depth--;
    end
    sent_items++;
    if (sent_items % 150 == 0) src_calm = !src_calm;
    @(negedge clk);
  endtask

  // Hold the input side until every predicted event has come out
  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Open comments up to the full depth (legal), drop some text inside, close again
  task automatic deep_dive();
    int         k;
    logic [7:0] filler;
    if (gen_esc) send_item("a", 1'b0);
    while (gen_depth < DEPTH_LIMIT) send_item(CH_LBRACE, 1'b0);
    for (k = 0; k < 3; k++) begin
      send_item(CH_BSLASH, 1'b0);
      send_item(($urandom_range(0, 1) != 0) ? CH_LBRACE : CH_RBRACE, 1'b0);
      // keep the filler from starting an escape that would unescape the next brace
      filler = 8'($urandom_range(33, 122));
      if (filler == CH_BSLASH) filler = "a";
      send_item(filler, 1'b0);
    end
    while (gen_depth > 0) send_item(CH_RBRACE, 1'b0);
  endtask

  initial begin
    int          rand_items;
    int          roll;
    int          k;
    int          burst;
    logic        mid_done;
    logic [7:0]  c;
    err_t        finale;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    gen_depth     = 0;
    gen_esc       = 1'b0;
    src_calm      = 1'b0;
    sent_items    = 0;
    idle_cycles   = 0;
    sink_stall    = 0;
    sink_tick     = 0;
    sink_calm     = 1'b0;
    mid_done      = 1'b0;
    rand_items    = 0;
    sb = new(DEPTH_LIMIT);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed text: plain word ended by a blank, word ended by ';', lone ';'
    send_item("a", 1'b0);
    send_item("b", 1'b0);
    send_item(CH_SPACE, 1'b0);
    send_item("x", 1'b0);
    send_item(CH_SEMI, 1'b0);
    send_item(CH_SEMI, 1'b0);
    // escaped blank becomes a word char; a comment inside the word does not split it,
    // and an escaped close brace inside the comment is dropped
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_SPACE, 1'b0);
    send_item(CH_LBRACE, 1'b0);
    send_item("z", 1'b0);
    send_item(CH_LBRACE, 1'b0);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_RBRACE, 1'b0);
    send_item(CH_RBRACE, 1'b0);
    send_item(CH_RBRACE, 1'b0);
    send_item("r", 1'b0);
    // newline ends the word and starts a new line; byte extremes as word chars
    send_item(CH_LF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(CH_VT, 1'b0);
    send_item(8'h80, 1'b0);
    // end with a word open, then end with nothing open
    send_item(8'hA5, 1'b1);
    send_item(8'h5A, 1'b1);
    send_item(CH_CR, 1'b0);
    send_item(CH_FF, 1'b0);

    // Random text: mostly well-formed words, blanks, instructions and comments
    while (rand_items < RANDOM_ITEMS) begin
      if (!mid_done && rand_items >= RANDOM_ITEMS / 2) begin
        // let everything drain once, then take the comment depth to its limit
        mid_done      = 1'b1;
        s_axis_tvalid = 1'b0;
        wait_drained();
        deep_dive();
        rand_items += 30;
      end else if ($urandom_range(0, 249) == 0) begin
        deep_dive();
        rand_items += 30;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          burst = $urandom_range(2, 8);
          for (k = 0; k < burst; k++) send_item(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
          send_item(($urandom_range(0, 2) == 0) ? CH_SEMI : CH_SPACE, 1'b0);
          rand_items += burst + 1;
        end else if (roll < 86 - 5 || gen_esc || gen_depth != 0) begin
          if (roll < 35) c = 8'($urandom_range(8'h21, 8'h7E));
          else if (roll < 45) c = 8'($urandom_range(0, 255));
          else if (roll < 57) begin
            case ($urandom_range(0, 5))
              0: c = CH_SPACE;
              1: c = CH_TAB;
              2: c = CH_LF;
              3: c = CH_VT;
              4: c = CH_FF;
              default: c = CH_CR;
            endcase
          end
          else if (roll < 62) c = CH_SEMI;
          else if (roll < 69) c = CH_BSLASH;
          else if (roll < 77) c = CH_LBRACE;
          else c = CH_RBRACE;
          // keep unescaped braces legal until the planned error
          if (!gen_esc && c == CH_LBRACE && gen_depth >= DEPTH_LIMIT) c = "a";
          if (!gen_esc && c == CH_RBRACE && gen_depth == 0) c = "a";
          send_item(c, 1'b0);
          rand_items++;
        end else begin
          send_item(8'($urandom_range(0, 255)), 1'b1);
          rand_items++;
        end
      end
    end

    // Finish with one error picked at random; the latch then silences the block
    finale = err_t'($urandom_range(1, 4));
    if (gen_esc) send_item("a", 1'b0);
    case (finale)
      ERR_STRAY_CLOSE: begin
        while (gen_depth > 0) send_item(CH_RBRACE, 1'b0);
        send_item(CH_RBRACE, 1'b0);
      end
      ERR_END_ESCAPE: begin
        // sometimes inside a comment, where the escape still takes priority
        if ($urandom_range(0, 1) != 0 && gen_depth < DEPTH_LIMIT) send_item(CH_LBRACE, 1'b0);
        send_item(CH_BSLASH, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      ERR_END_COMMENT: begin
        if (gen_depth == 0) send_item(CH_LBRACE, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      ERR_TOO_DEEP: begin
        while (gen_depth < DEPTH_LIMIT) send_item(CH_LBRACE, 1'b0);
        send_item(CH_LBRACE, 1'b0);
      end
      default: ;
    endcase
    // these must all be swallowed
    for (k = 0; k < 12; k++) begin
      send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    s_axis_tvalid = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("word_tokenizer_nested_comments verification clean");
    end else begin
      $display("word_tokenizer_nested_comments verification failed");
    end
    $finish;
  end

endmodule
